FILE: rtl/blide_pkg.sv
// Package for the bounded list insert/delete engine: codes, payload types, defaults.
`default_nettype none
package blide_pkg;

  // Default number of entries held by the store
  localparam int unsigned CapacityDefault = 16;

  // Operation codes
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/blide_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module blide_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/bounded_list_insert_delete_engine.sv
// Top level: ring-buffer deque with delete-by-value, driven by a small sequencer.
// Sequence: an insert, a full reject, a delete on an empty list or an unused code goes
// straight to the result; any other delete compares entries from the front until a match
// or the end, then shifts each later entry down a slot through the single registered read port.
// One transaction in flight: the next is accepted in the cycle after the result is loaded, and
// a stalled result holds the sequencer. Reset clears count, front index and control, not the RAM.
`default_nettype none
module bounded_list_insert_delete_engine #(
  parameter int unsigned CAPACITY = blide_pkg::CapacityDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire blide_pkg::in_t  in_data_i,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      blide_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN_RD  = 6'b000010,
    ST_SCAN_CMP = 6'b000100,
    ST_SHIFT_RD = 6'b001000,
    ST_SHIFT_WR = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]    front_q, front_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         status_q, status_d;
  logic [31:0]        removed_q, removed_d;
  logic               out_valid_q, out_valid_d;
  blide_pkg::out_t    out_data_q, out_data_d;

  // RAM port signals
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [31:0]        ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [31:0]        ram_rdata;

  // Ring arithmetic helpers
  logic [IdxW-1:0]    ptr_next;
  logic [IdxW-1:0]    front_dec;
  logic [CntW:0]      back_sum;
  logic [IdxW-1:0]    back_slot;
  logic               is_full;
  logic               in_fire;
  logic [CntW-1:0]    idx_plus1;
  logic [CntW-1:0]    idx_plus2;

  assign ptr_next  = (ptr_q == IdxW'(CAPACITY - 1)) ? '0 : ptr_q + IdxW'(1);
  assign front_dec = (front_q == '0) ? IdxW'(CAPACITY - 1) : front_q - IdxW'(1);
  assign back_sum  = (CntW + 1)'(front_q) + (CntW + 1)'(count_q);
  assign back_slot = (back_sum >= (CntW + 1)'(CAPACITY))
                   ? IdxW'(back_sum - (CntW + 1)'(CAPACITY)) : IdxW'(back_sum);
  assign is_full   = (count_q >= CntW'(CAPACITY));
  assign idx_plus1 = CntW'(idx_q) + CntW'(1);
  assign idx_plus2 = CntW'(idx_q) + CntW'(2);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    key_d       = key_q;
    status_d    = status_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = ptr_q;

    // Output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d     = in_data_i.item_value;
          status_d  = blide_pkg::STAT_DONE;
          removed_d = '0;
          ptr_d     = front_q;
          idx_d     = '0;
          state_d   = ST_FINISH;
          case (in_data_i.operation)
            blide_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = blide_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                ram_wdata = in_data_i.item_value;
                front_d   = front_dec;
                count_d   = count_q + CntW'(1);
              end
            end
            blide_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = blide_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_slot;
                ram_wdata = in_data_i.item_value;
                count_d   = count_q + CntW'(1);
              end
            end
            blide_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                status_d = blide_pkg::STAT_MISS;
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
            default: begin
              // undefined operation: ignored, reports done
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        ram_raddr = ptr_q;
        state_d   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (ram_rdata == key_q) begin
          removed_d = ram_rdata;
          if (idx_plus1 < count_q) begin
            state_d = ST_SHIFT_RD;
          end else begin
            count_d = count_q - CntW'(1);
            state_d = ST_FINISH;
          end
        end else if (idx_plus1 >= count_q) begin
          status_d = blide_pkg::STAT_MISS;
          state_d  = ST_FINISH;
        end else begin
          ptr_d   = ptr_next;
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        // fetch the entry behind the gap
        ram_raddr = ptr_next;
        state_d   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_next;
        idx_d     = idx_q + IdxW'(1);
        if (idx_plus2 < count_q) begin
          state_d = ST_SHIFT_RD;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = status_q;
          out_data_d.removed_value   = removed_q;
          out_data_d.entry_count     = 5'(count_q);
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    idx_q      <= idx_d;
    key_q      <= key_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    out_data_q <= out_data_d;
  end

  // Entry store
  blide_ram #(
    .Width (32),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the bounded list insert/delete engine.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity   = blide_pkg::CapacityDefault;
  localparam int          RandomOps  = 1600;
  localparam int          TailOps    = 200;   // final stretch runs with no idling
  localparam int          DrainEvery = 250;
  localparam int          CycleLimit = 1_000_000;
  localparam int          SettleCycles = 4 * Capacity + 16;

  // Code 3 has no meaning and must be ignored by the engine
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic signed [31:0] MostPositive = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MostNegative = 32'sh8000_0000;
  localparam logic signed [31:0] AllOnes      = -32'sd1;

  typedef logic signed [31:0] word_q_t[$];

  // One pending stimulus transaction; wait_drain holds it back until all results are in
  typedef struct packed {
    logic            wait_drain;
    blide_pkg::in_t  payload;
  } queued_op_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  blide_pkg::in_t  in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  blide_pkg::out_t out_data_o;

  queued_op_t      queued_ops[$];
  blide_pkg::out_t pending_results[$];
  word_q_t    list_contents;   // predictor copy, advanced on each accepted transaction
  word_q_t    planned_contents; // used only while generating stimulus

  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   ready_stall = 0;
  int   send_pct = 10;
  int   stall_pct = 10;
  int   cycle_count = 0;
  int   error_count = 0;
  int   results_checked = 0;
  int   hits_seen = 0;
  int   misses_seen = 0;
  int   full_seen = 0;
  int   ignored_seen = 0;
  int   peak_count = 0;

  bounded_list_insert_delete_engine #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Expected outcome of one transaction; updates the given list in place
  function automatic blide_pkg::out_t list_outcome(ref word_q_t lst,
                                                   input blide_pkg::in_t req);
    blide_pkg::out_t res;
    int              hit;
    res = '0;
    hit = -1;
    case (req.operation)
      blide_pkg::OP_PUSH_FRONT, blide_pkg::OP_PUSH_BACK: begin
        if (lst.size() >= Capacity) begin
          res.status = blide_pkg::STAT_FULL;
        end else if (req.operation == blide_pkg::OP_PUSH_FRONT) begin
          lst.push_front(req.item_value);
        end else begin
          lst.push_back(req.item_value);
        end
      end
      blide_pkg::OP_DELETE: begin
        // first match counted from the front
        for (int i = 0; i < lst.size(); i++) begin
          if (hit < 0 && lst[i] == req.item_value) hit = i;
        end
        if (hit < 0) begin
          res.status = blide_pkg::STAT_MISS;
        end else begin
          res.removed_value = lst[hit];
          lst.delete(hit);
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(lst.size());
    return res;
  endfunction

  task automatic add_op(input logic [1:0] op, input logic signed [31:0] val,
                        input logic drain);
    queued_op_t q;
    q.wait_drain         = drain;
    q.payload.operation  = op;
    q.payload.item_value = val;
    queued_ops.push_back(q);
    void'(list_outcome(planned_contents, q.payload));
  endtask

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Reset: held low at start, released at a falling edge
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Cycle counter, idle-rate changes and timeout
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count % 512 == 0) begin
      case ($urandom_range(0, 3))
        0: send_pct = 0;
        1: send_pct = 5;
        2: send_pct = 20;
        default: send_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 5;
        2: stall_pct = 20;
        default: stall_pct = 50;
      endcase
    end
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("bounded_list_insert_delete_engine regression: fail");
      $finish;
    end
  end

  // Input driver: one transaction per handshake, bursts of idle in between
  always @(negedge clk_i) begin
    queued_op_t nx;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold until accepted
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid_i <= 1'b0;
    end else if (queued_ops.size() == 0 ||
                 (queued_ops[0].wait_drain && pending_results.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else if (queued_ops.size() > TailOps && $urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      send_gap = $urandom_range(0, 15);
    end else begin
      nx = queued_ops.pop_front();
      in_valid_i <= 1'b1;
      in_data_i  <= nx.payload;
    end
  end

  // Output back-pressure in bursts
  always @(negedge clk_i) begin
    if (ready_stall > 0) begin
      ready_stall = ready_stall - 1;
      out_ready_i <= 1'b0;
    end else if (queued_ops.size() > TailOps && $urandom_range(0, 99) < stall_pct) begin
      ready_stall = $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: check results, then predict for newly accepted transactions
  always @(posedge clk_i) begin
    blide_pkg::out_t exp_res;
    blide_pkg::out_t got;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d removed=%0d count=%0d",
                                got.status, got.removed_value, got.entry_count));
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (got.status !== exp_res.status)
          note_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_checked, got.status, exp_res.status));
        if (got.removed_value !== exp_res.removed_value)
          note_mismatch($sformatf("result %0d removed_value %0d, expected %0d",
                                  results_checked, got.removed_value,
                                  exp_res.removed_value));
        if (got.entry_count !== exp_res.entry_count)
          note_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                  results_checked, got.entry_count,
                                  exp_res.entry_count));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      exp_res = list_outcome(list_contents, in_data_i);
      pending_results.push_back(exp_res);
      if (in_data_i.operation == OpUnused) ignored_seen++;
      else if (exp_res.status == blide_pkg::STAT_FULL) full_seen++;
      else if (exp_res.status == blide_pkg::STAT_MISS) misses_seen++;
      else if (in_data_i.operation == blide_pkg::OP_DELETE) hits_seen++;
      if (int'(exp_res.entry_count) > peak_count) peak_count = int'(exp_res.entry_count);
    end
  end

  // Stimulus and end of run
  initial begin
    int                 n;
    int                 trend;
    int                 ins_pct;
    int                 roll;
    logic [1:0]         op;
    logic signed [31:0] val;

    // Directed: empty store, ignored code, single entry, fill, full, duplicates
    add_op(blide_pkg::OP_DELETE, 32'sd0, 1'b0);
    add_op(OpUnused, AllOnes, 1'b0);
    add_op(blide_pkg::OP_PUSH_BACK, MostPositive, 1'b0);
    add_op(blide_pkg::OP_DELETE, 32'sd1, 1'b0);          // single entry, no match
    add_op(blide_pkg::OP_DELETE, MostPositive, 1'b0);    // single entry, match
    for (int i = 0; i < Capacity; i++) begin
      op = i[0] ? blide_pkg::OP_PUSH_BACK : blide_pkg::OP_PUSH_FRONT;
      case (i)
        0: val = MostNegative;
        1: val = AllOnes;
        2: val = 32'sd0;
        3, 4, 5: val = 32'sd7;
        6: val = MostPositive;
        default: val = $urandom();
      endcase
      add_op(op, val, 1'b0);
    end
    add_op(blide_pkg::OP_PUSH_BACK, 32'sd99, 1'b0);      // full
    add_op(blide_pkg::OP_PUSH_FRONT, 32'sd98, 1'b0);     // full
    add_op(OpUnused, 32'sd5, 1'b0);
    add_op(blide_pkg::OP_DELETE, 32'sd7, 1'b0);          // first of several duplicates
    add_op(blide_pkg::OP_DELETE, 32'sd12345, 1'b0);      // no match

    // Random: phases that grow, shrink or hold the list level
    n = 0;
    trend = 2;
    while (n < RandomOps) begin
      if (n % 100 == 0) trend = $urandom_range(0, 2);
      ins_pct = (trend == 0) ? 75 : (trend == 1) ? 30 : 52;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OpUnused;
      else if (roll < 2 + ins_pct)
        op = $urandom_range(0, 1) ? blide_pkg::OP_PUSH_BACK : blide_pkg::OP_PUSH_FRONT;
      else op = blide_pkg::OP_DELETE;
      val = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2: val = $urandom_range(0, 7) - 4;   // small range gives duplicates
        3: begin
          case ($urandom_range(0, 3))
            0: val = MostPositive;
            1: val = MostNegative;
            2: val = 32'sd0;
            default: val = AllOnes;
          endcase
        end
        default: ;
      endcase
      // most deletes target a value that is present
      if (op == blide_pkg::OP_DELETE && planned_contents.size() > 0 &&
          $urandom_range(0, 3) != 0)
        val = planned_contents[$urandom_range(0, planned_contents.size() - 1)];
      add_op(op, val, (n % DrainEvery) == 0);
      if (op != OpUnused) n++;
    end

    while (queued_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("checked %0d results: %0d delete hits, %0d misses, %0d full rejects, %0d ignored",
             results_checked, hits_seen, misses_seen, full_seen, ignored_seen);
    $display("peak occupancy %0d of %0d, %0d cycles, %0d mismatches",
             peak_count, Capacity, cycle_count, error_count);
    if (error_count == 0) begin
      $display("bounded_list_insert_delete_engine regression: pass");
    end else begin
      $display("bounded_list_insert_delete_engine regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
